// File: rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants and types of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NumOrders     = 11;
  localparam int PageIndexBits = 16;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusNoMem   = 2'd1,
    StatusDupFree = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StAllocCnt,
    StAllocScan,
    StSplit,
    StFreeChk,
    StFreeLoop,
    StFreeBud,
    StFreeRe,
    StFreeRe2,
    StPutTake,
    StPutInc
  } state_e;

endpackage

// File: rtl/core/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy allocator over 2^PAGE_INDEX_BITS pages with per-page free tags.
// ----------------------------------------------------------------------------
// One request at a time: start_i is taken while busy_o is low and the result
// appears on valid_o for a single cycle; it cannot be held off. After reset a
// clearing pass runs through every page of the tag memory with busy_o high. A
// free checks for a double free and then merges with its buddy while it is free.
// An allocation steps up through the empty orders, then scans the tag memory
// (one read and one write port) at one page per cycle up to the chosen block,
// then splits it down to the requested order.
module buddy_page_allocator #(
  parameter int NUM_ORDERS      = bpa_pkg::NumOrders,
  parameter int PAGE_INDEX_BITS = bpa_pkg::PageIndexBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [3:0]  order_i,
  input  logic [15:0] page_index_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] block_index_o
);

  localparam int PB         = PAGE_INDEX_BITS;
  localparam int TW         = $clog2(NUM_ORDERS + 1);
  localparam int OW         = $clog2(NUM_ORDERS);
  localparam int CW         = PB + 1;
  localparam int PAGE_COUNT = 1 << PB;

  logic [TW-1:0] mem [PAGE_COUNT];
  logic [TW-1:0] rdata_q;
  logic [CW-1:0] cnt_q [NUM_ORDERS];

  bpa_pkg::state_e state_q, state_d;
  logic [TW-1:0] k_q, k_d, o_q, o_d, put_k_q, put_k_d;
  logic [PB-1:0] p_q, p_d, put_addr_q, put_addr_d;
  logic [PB:0]   scan_q, scan_d;
  logic [PB-1:0] clr_q, clr_d;
  logic          alloc_q, alloc_d;
  logic          valid_q, valid_d;
  logic [1:0]    status_q, status_d;
  logic [PB-1:0] blk_q, blk_d;

  logic          mem_we;
  logic [PB-1:0] mem_wa, rd_addr;
  logic [TW-1:0] mem_wd;
  logic          cnt_we;
  logic [OW-1:0] cnt_idx;
  logic [CW-1:0] cnt_wd;

  logic [TW-1:0] k1;
  logic [PB-1:0] kbit, bud, bud_k1;
  logic [OW-1:0] tidx;

  always_comb begin
    k1     = k_q + TW'(1);
    kbit   = PB'(1) << k_q;
    bud    = p_q ^ kbit;
    bud_k1 = p_q ^ (PB'(1) << (k_q - TW'(1)));
    tidx   = OW'(rdata_q - TW'(1));
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    o_d        = o_q;
    p_d        = p_q;
    put_k_d    = put_k_q;
    put_addr_d = put_addr_q;
    scan_d     = scan_q;
    clr_d      = clr_q;
    alloc_d    = alloc_q;
    valid_d    = 1'b0;
    status_d   = status_q;
    blk_d      = blk_q;
    mem_we     = 1'b0;
    mem_wa     = put_addr_q;
    mem_wd     = '0;
    rd_addr    = put_addr_q;
    cnt_we     = 1'b0;
    cnt_idx    = OW'(k_q);
    cnt_wd     = '0;
    unique case (state_q)
      bpa_pkg::StClear: begin
        mem_we = 1'b1;
        mem_wa = clr_q[PB-1:0];
        clr_d  = clr_q + 1'b1;
        if (clr_q[PB-1:0] == '1) state_d = bpa_pkg::StIdle;
      end
      bpa_pkg::StIdle: begin
        rd_addr = PB'(page_index_i);
        if (start_i) begin
          alloc_d = !action_i;
          blk_d   = '0;
          if (32'(order_i) >= NUM_ORDERS) begin
            valid_d  = 1'b1;
            status_d = action_i ? bpa_pkg::StatusOk : bpa_pkg::StatusNoMem;
          end else if (!action_i) begin
            k_d     = TW'(order_i);
            o_d     = TW'(order_i);
            state_d = bpa_pkg::StAllocCnt;
          end else if (PB'(page_index_i) == '0) begin
            valid_d  = 1'b1;
            status_d = bpa_pkg::StatusOk;
          end else begin
            k_d     = TW'(order_i);
            p_d     = PB'(page_index_i);
            state_d = bpa_pkg::StFreeChk;
          end
        end
      end
      bpa_pkg::StAllocCnt: begin
        if (32'(k_q) >= NUM_ORDERS) begin
          valid_d  = 1'b1;
          status_d = bpa_pkg::StatusNoMem;
          state_d  = bpa_pkg::StIdle;
        end else if (cnt_q[OW'(k_q)] == '0) begin
          k_d = k1;
        end else begin
          scan_d  = '0;
          state_d = bpa_pkg::StAllocScan;
        end
      end
      bpa_pkg::StAllocScan: begin
        // reads run one page ahead of the compare
        rd_addr = scan_q[PB-1:0];
        if (scan_q != '0 && rdata_q == k1) begin
          p_d    = PB'(scan_q - 1'b1);
          mem_we = 1'b1;
          mem_wa = PB'(scan_q - 1'b1);
          if (cnt_q[OW'(k_q)] != '0) begin
            cnt_we = 1'b1;
            cnt_wd = cnt_q[OW'(k_q)] - 1'b1;
          end
          state_d = bpa_pkg::StSplit;
        end else if (scan_q[PB]) begin
          cnt_we   = 1'b1;
          valid_d  = 1'b1;
          status_d = bpa_pkg::StatusNoMem;
          state_d  = bpa_pkg::StIdle;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      bpa_pkg::StSplit: begin
        rd_addr = bud_k1;
        if (k_q > o_q) begin
          k_d = k_q - TW'(1);
          if (32'(k_q) - 1 < PB) begin
            put_addr_d = bud_k1;
            put_k_d    = k_q - TW'(1);
            state_d    = bpa_pkg::StPutTake;
          end
        end else begin
          valid_d  = 1'b1;
          status_d = bpa_pkg::StatusOk;
          blk_d    = p_q;
          state_d  = bpa_pkg::StIdle;
        end
      end
      bpa_pkg::StFreeChk: begin
        if (rdata_q == k1) begin
          valid_d  = 1'b1;
          status_d = bpa_pkg::StatusDupFree;
          state_d  = bpa_pkg::StIdle;
        end else begin
          state_d = bpa_pkg::StFreeLoop;
        end
      end
      bpa_pkg::StFreeLoop: begin
        if (32'(k_q) + 1 >= NUM_ORDERS || 32'(k_q) >= PB) begin
          rd_addr    = p_q;
          put_addr_d = p_q;
          put_k_d    = k_q;
          state_d    = bpa_pkg::StPutTake;
        end else begin
          rd_addr    = bud;
          put_addr_d = bud;
          state_d    = bpa_pkg::StFreeBud;
        end
      end
      bpa_pkg::StFreeBud: begin
        if (rdata_q != k1) begin
          rd_addr    = p_q;
          put_addr_d = p_q;
          put_k_d    = k_q;
          state_d    = bpa_pkg::StPutTake;
        end else begin
          // absorb the buddy and climb one order
          mem_we = 1'b1;
          mem_wa = put_addr_q;
          if (cnt_q[OW'(k_q)] != '0) begin
            cnt_we = 1'b1;
            cnt_wd = cnt_q[OW'(k_q)] - 1'b1;
          end
          if (put_addr_q < p_q) p_d = put_addr_q;
          k_d     = k1;
          state_d = bpa_pkg::StFreeRe;
        end
      end
      bpa_pkg::StFreeRe: begin
        rd_addr = p_q;
        state_d = bpa_pkg::StFreeRe2;
      end
      bpa_pkg::StFreeRe2: begin
        if (rdata_q == k1) begin
          valid_d  = 1'b1;
          status_d = bpa_pkg::StatusOk;
          state_d  = bpa_pkg::StIdle;
        end else begin
          state_d = bpa_pkg::StFreeLoop;
        end
      end
      bpa_pkg::StPutTake: begin
        // drop whatever block started here, then tag the new one
        if (rdata_q != '0 && 32'(rdata_q) <= NUM_ORDERS && cnt_q[tidx] != '0) begin
          cnt_we  = 1'b1;
          cnt_idx = tidx;
          cnt_wd  = cnt_q[tidx] - 1'b1;
        end
        mem_we  = 1'b1;
        mem_wd  = put_k_q + TW'(1);
        state_d = bpa_pkg::StPutInc;
      end
      bpa_pkg::StPutInc: begin
        cnt_we  = 1'b1;
        cnt_idx = OW'(put_k_q);
        cnt_wd  = cnt_q[OW'(put_k_q)] + 1'b1;
        if (alloc_q) begin
          state_d = bpa_pkg::StSplit;
        end else begin
          valid_d  = 1'b1;
          status_d = bpa_pkg::StatusOk;
          state_d  = bpa_pkg::StIdle;
        end
      end
      default: state_d = bpa_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ORDERS; i++) cnt_q[i] <= '0;
    end else if (cnt_we) begin
      cnt_q[cnt_idx] <= cnt_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::StClear;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    o_q        <= o_d;
    p_q        <= p_d;
    put_k_q    <= put_k_d;
    put_addr_q <= put_addr_d;
    scan_q     <= scan_d;
    alloc_q    <= alloc_d;
    status_q   <= status_d;
    blk_q      <= blk_d;
  end

  assign busy_o        = (state_q != bpa_pkg::StIdle);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign block_index_o = 16'(blk_q);

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && action_i == 1'b0 && 32'(order_i) < NUM_ORDERS |=> busy_o)
    else $error("allocate request not taken up");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != bpa_pkg::StatusOk |-> block_index_o == '0)
    else $error("failed request returned a block");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> status_o != 2'd3)
    else $error("undefined status code");
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o || $past(start_i))
    else $error("result while still busy");
`endif

endmodule
